@@ hdl/i2d_pkg.sv @@
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the integer to decimal ASCII unit: transfer
// payloads, digit cell control and the sequencer states.
// ----------------------------------------------------------------------------
package i2d_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int CNT_W      = 4;
   localparam int BIT_CNT_W  = $clog2(WORD_W);
   localparam int IDX_W      = $clog2(NUM_DIGITS);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Input transfer payload
   typedef struct packed {
      logic [WORD_W-1:0] value_bits;
      logic              signed_mode;
   } req_type;

   // Result transfer payload, one per character
   typedef struct packed {
      logic [7:0]       ascii_char;
      logic             last_char;
      logic [CNT_W-1:0] char_count;
   } rsp_type;

   // Control shared by every digit cell of the chain
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } state_type;

endpackage

@@ hdl/i2d_cell.sv @@
// ----------------------------------------------------------------------------
// i2d_cell
// One BCD digit cell of the shift-and-add-3 chain. Each shift it corrects
// its digit, passes the top bit to the next cell and takes the bit below.
// ----------------------------------------------------------------------------
module i2d_cell (
   input  logic                   clock,
   input  i2d_pkg::cell_ctrl_type ctrl,
   input  logic                   shift_in,
   output logic                   carry_out,
   output logic [3:0]             digit
);
   import i2d_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] corr;

   // Add 3 when the digit would overflow past 9 after doubling
   always_comb begin
      corr      = (digit_ff >= DIGIT_W'(5)) ? digit_ff + DIGIT_W'(3) : digit_ff;
      carry_out = corr[DIGIT_W-1];
      priority if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = {corr[DIGIT_W-2:0], shift_in};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

@@ hdl/int_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Formats a 32-bit word, signed or unsigned, as decimal ASCII characters,
// most significant first, one result transfer per character.
// ----------------------------------------------------------------------------
// An input transfer is taken only while the unit is idle. The magnitude is
// shifted one bit per cycle through a chain of ten BCD digit cells; a sizing
// step then finds the leading digit, and the characters leave at one per
// cycle while the result side does not stall. An item makes 1 to 11
// characters. The next input transfer is taken as soon as the final
// character sits in the output register, even while it still waits to be
// taken.
module int_to_decimal_ascii_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i2d_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i2d_pkg::rsp_type rsp_data
);
   import i2d_pkg::*;

   state_type             state_ff, state_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [WORD_W-1:0]     mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  sign_pend_ff, sign_pend_in;
   logic [IDX_W-1:0]      digit_idx_ff, digit_idx_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   cell_ctrl_type         cell_ctrl;
   logic [DIGIT_W-1:0]    digit [NUM_DIGITS];
   logic                  carry [NUM_DIGITS];
   logic                  req_accept;
   logic                  out_adv;
   logic                  is_neg;
   logic [IDX_W-1:0]      top_idx;

   // Digit cell chain, least significant digit at cell 0
   for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
      logic cell_in;
      if (g == 0) begin : g_first
         assign cell_in = mag_ff[WORD_W-1];
      end else begin : g_rest
         assign cell_in = carry[g-1];
      end
      i2d_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .shift_in  (cell_in),
         .carry_out (carry[g]),
         .digit     (digit[g])
      );
   end

   // Find the highest nonzero digit; zero keeps a single digit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digit[i] != '0) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_adv    = !rsp_valid_ff || !rsp_stall;
   assign is_neg     = req_data.signed_mode && req_data.value_bits[WORD_W-1];

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      digit_idx_in = digit_idx_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cell_ctrl    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mag_in          = is_neg ? WORD_W'(0) - req_data.value_bits
                                        : req_data.value_bits;
               neg_in          = is_neg;
               bit_cnt_in      = '0;
               cell_ctrl.clear = 1'b1;
               state_in        = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // Advance one magnitude bit into the chain
            cell_ctrl.shift = 1'b1;
            mag_in          = {mag_ff[WORD_W-2:0], 1'b0};
            bit_cnt_in      = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(WORD_W - 1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            digit_idx_in = top_idx;
            total_in     = CNT_W'(top_idx) + CNT_W'(1) + CNT_W'(neg_ff);
            sign_pend_in = neg_ff;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // Load the next character when the output register frees up
            if (out_adv) begin
               rsp_valid_in = 1'b1;
               if (sign_pend_ff) begin
                  rsp_in.ascii_char = CHAR_MINUS;
                  rsp_in.last_char  = 1'b0;
                  rsp_in.char_count = '0;
                  sign_pend_in      = 1'b0;
               end else begin
                  rsp_in.ascii_char = CHAR_ZERO + {4'b0000, digit[digit_idx_ff]};
                  rsp_in.last_char  = (digit_idx_ff == '0);
                  rsp_in.char_count = (digit_idx_ff == '0) ? total_ff : '0;
                  if (digit_idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     digit_idx_in = digit_idx_ff - IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      bit_cnt_ff   <= bit_cnt_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      sign_pend_ff <= sign_pend_in;
      digit_idx_ff <= digit_idx_in;
      total_ff     <= total_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A final character carries a count, every other one carries zero
   a_last_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_char |-> rsp_ff.char_count != '0)
      else $error("final character without a count");

   a_mid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_char |-> rsp_ff.char_count == '0)
      else $error("count on a character that is not final");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.ascii_char == CHAR_MINUS) ||
                       ((rsp_ff.ascii_char >= CHAR_ZERO) &&
                        (rsp_ff.ascii_char <= CHAR_NINE)))
      else $error("character outside sign and digits");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_CONVERT)
      else $error("accepted transfer did not start a conversion");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks int_to_decimal_ascii_unit. Words go in signed and unsigned; every
// character that comes out is compared field by field against a decimal
// formatter kept here. Both sides idle at random. A long receiver hold-off
// fills the unit and stalls its input, and the sender drains between phases.
// ----------------------------------------------------------------------------
module testbench;
   import i2d_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int LONG_HOLD     = 400;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int TAIL_CYCLES   = 80;
   localparam int RANDOM_WORDS  = 78;
   localparam int BURST_WORDS   = 6;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_chars[$];
   int      error_count = 0;
   int      words_sent = 0;
   int      negatives_sent = 0;
   int      chars_checked = 0;

   // Idling controls for both sides
   bit      req_idle_on = 1'b0;
   bit      rsp_idle_on = 1'b0;
   int      holds_asked = 0;

   int_to_decimal_ascii_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Queue the characters that a word must produce, most significant first
   function automatic void queue_decimal_text(input req_type item);
      logic [31:0] magnitude;
      logic        negative;
      logic [3:0]  digits [10];
      int          ndig;
      int          total;
      rsp_type     ch;
      negative  = item.signed_mode && item.value_bits[31];
      magnitude = negative ? (32'd0 - item.value_bits) : item.value_bits;
      ndig = 0;
      do begin
         digits[ndig] = 4'(magnitude % 10);
         ndig++;
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      total = ndig + (negative ? 1 : 0);
      if (negative) begin
         ch.ascii_char = CHAR_MINUS;
         ch.last_char  = 1'b0;
         ch.char_count = '0;
         expected_chars.push_back(ch);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
         ch.ascii_char = CHAR_ZERO + 8'(digits[i]);
         ch.last_char  = (i == 0);
         ch.char_count = (i == 0) ? CNT_W'(total) : '0;
         expected_chars.push_back(ch);
      end
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Favor digit-count boundaries and the sign edge over plain random words
   function automatic logic [31:0] pick_word();
      logic [31:0] p;
      int          e;
      case ($urandom_range(0, 6))
         0: return $urandom_range(0, 9);
         1: return $urandom_range(10, 99999);
         2: begin
            e = $urandom_range(1, 9);
            p = 1;
            repeat (e) p = p * 10;
            return p + $urandom_range(0, 2) - 1;
         end
         3: return 32'h8000_0000 + $urandom_range(0, 2) - 1;
         4: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default: return $urandom();
      endcase
   endfunction

   // Offer one word, hold it until the transfer, then record its text
   task automatic send_word(input logic [31:0] value, input logic signed_mode);
      req_type item;
      int      gap;
      item.value_bits  = value;
      item.signed_mode = signed_mode;
      gap = 0;
      if (req_idle_on && $urandom_range(0, 1))
         gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      queue_decimal_text(item);
      words_sent++;
      if (signed_mode && value[31])
         negatives_sent++;
   endtask

   // Stop offering and wait until every character has been taken
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_extremes();
      send_word(32'd0, 1'b0);
      send_word(32'd0, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b1);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'd9, 1'b1);
      send_word(32'd10, 1'b0);
      send_word(32'd999_999_999, 1'b0);
      send_word(32'd1_000_000_000, 1'b1);
      send_word(-32'sd10, 1'b1);
      send_word(32'd1, 1'b1);
      send_word(32'hAAAA_5555, 1'b1);
      send_word(32'h5555_AAAA, 1'b0);
      wait_for_drain();
   endtask

   task automatic test_random_words();
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      repeat (RANDOM_WORDS)
         send_word(pick_word(), 1'($urandom_range(0, 1)));
      wait_for_drain();
   endtask

   // Hold the result side off while words keep coming, so the unit fills up
   task automatic test_output_backpressure();
      req_idle_on = 1'b0;
      holds_asked <= holds_asked + 1;
      repeat (BURST_WORDS)
         send_word(pick_word(), 1'($urandom_range(0, 1)));
      wait_for_drain();
   endtask

   // Receiver: random stall phases, plus a long hold-off on request
   always @(posedge clock) begin
      static int phase_left   = 0;
      static int hold_left    = 0;
      static int holds_served = 0;
      if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!rsp_idle_on) begin
         rsp_stall <= 1'b0;
      end else if (phase_left > 0) begin
         phase_left--;
      end else if ($urandom_range(0, 1)) begin
         rsp_stall  <= 1'b0;
         phase_left = $urandom_range(0, 15);
      end else begin
         rsp_stall  <= 1'b1;
         phase_left = idle_length() - 1;
      end
   end

   // Compare each result transfer with the oldest expected character
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character %h with nothing pending", rsp_data.ascii_char);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_data.ascii_char !== want.ascii_char) begin
               $error("ascii_char: expected %h, got %h",
                      want.ascii_char, rsp_data.ascii_char);
               error_count++;
            end
            if (rsp_data.last_char !== want.last_char) begin
               $error("last_char: expected %b, got %b",
                      want.last_char, rsp_data.last_char);
               error_count++;
            end
            if (rsp_data.char_count !== want.char_count) begin
               $error("char_count: expected %0d, got %0d",
                      want.char_count, rsp_data.char_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens for too long
   always @(posedge clock) begin
      static int quiet_cycles = 0;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $error("no transfer for %0d cycles", WATCHDOG_MAX);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_random_words();
      test_output_backpressure();

      // Let any stray character show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $error("%0d expected characters never arrived", expected_chars.size());
         error_count++;
      end

      $display("Covered %0d words (%0d negative in signed mode), %0d characters checked,",
               words_sent, negatives_sent, chars_checked);
      $display("including zero, both word extremes and a long output hold-off.");
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
